// ----- hdl/bhms_pkg.sv -----
// Package for the button to HID mode sequencer.
// Holds the transfer payload types, the mode encoding, button and usage codes.
// No dependencies.
package bhms_pkg;

  localparam logic [2:0] BTN_UP    = 3'd0;
  localparam logic [2:0] BTN_DOWN  = 3'd1;
  localparam logic [2:0] BTN_LEFT  = 3'd2;
  localparam logic [2:0] BTN_RIGHT = 3'd3;
  localparam logic [2:0] BTN_OK    = 3'd4;
  localparam logic [2:0] BTN_BACK  = 3'd5;

  localparam logic [1:0] KIND_SHORT = 2'd0;
  localparam logic [1:0] KIND_LONG  = 2'd1;

  localparam logic [7:0] USE_GUI   = 8'hE3;
  localparam logic [7:0] USE_TAB   = 8'h2B;
  localparam logic [7:0] USE_RET   = 8'h28;
  localparam logic [7:0] USE_RIGHT = 8'h4F;
  localparam logic [7:0] USE_LEFT  = 8'h50;
  localparam logic [7:0] USE_DOWN  = 8'h51;
  localparam logic [7:0] USE_UP    = 8'h52;

  localparam int unsigned MaxRecs    = 3;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    MODE_MAIN = 2'd0,
    MODE_APPS = 2'd1,
    MODE_WINS = 2'd2,
    MODE_EXIT = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0] button;
    logic [1:0] press_kind;
  } evt_t;

  typedef struct packed {
    logic       report_valid;
    logic       report_release;
    logic [7:0] usage_code;
    logic [1:0] mode_now;
    logic       modifier_held;
    logic       exit_done;
    logic       last;
  } report_t;

  typedef struct packed {
    logic       act;
    logic       rel;
    logic [7:0] code;
    logic       mod;
  } rec_t;

  typedef struct packed {
    rec_t [MaxRecs-1:0] recs;
    logic [1:0]         cnt;
    mode_e              mode;
    logic               exit_flag;
  } plan_t;

  function automatic logic is_dir(logic [2:0] button);
    return (button == BTN_UP) || (button == BTN_DOWN) ||
           (button == BTN_LEFT) || (button == BTN_RIGHT);
  endfunction

  function automatic logic [7:0] remap_usage(logic [2:0] button);
    logic [7:0] code;
    code = USE_UP;
    case (button)
      BTN_LEFT:  code = USE_UP;
      BTN_UP:    code = USE_RIGHT;
      BTN_RIGHT: code = USE_DOWN;
      BTN_DOWN:  code = USE_LEFT;
      default:   code = USE_UP;
    endcase
    return code;
  endfunction

  function automatic rec_t mk_rec(logic rel, logic [7:0] code, logic mod);
    rec_t r;
    r.act  = 1'b1;
    r.rel  = rel;
    r.code = code;
    r.mod  = mod;
    return r;
  endfunction

endpackage

// ----- hdl/bhms_front.sv -----
// Front end: accepts button events, runs the mode machine and builds a record plan.
// Depends on bhms_pkg.
module bhms_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bhms_pkg::evt_t evt_i,
  input  logic           evt_valid_i,
  output logic           evt_ready_o,
  input  logic           queue_full_i,
  output logic           push_o,
  output bhms_pkg::plan_t plan_o
);
  import bhms_pkg::*;

  mode_e mode_q, mode_d;
  logic  gui_q, gui_d;
  logic  exit_q, exit_d;

  logic       press_en, tap_en, rel_en;
  logic [7:0] tap_code;
  logic       shrt;
  logic       mod_tap;
  logic [1:0] n;

  assign evt_ready_o = !queue_full_i;
  assign push_o      = evt_valid_i && evt_ready_o;
  assign shrt        = (evt_i.press_kind == KIND_SHORT);

  always_comb begin
    press_en = 1'b0;
    tap_en   = 1'b0;
    rel_en   = 1'b0;
    tap_code = USE_TAB;
    mode_d   = mode_q;
    exit_d   = exit_q;
    if (!exit_q) begin
      unique case (mode_q)
        MODE_MAIN: begin
          if (shrt) begin
            if (evt_i.button == BTN_OK) begin
              press_en = !gui_q;
              tap_en   = 1'b1;
              tap_code = USE_TAB;
              mode_d   = MODE_APPS;
            end else if (is_dir(evt_i.button)) begin
              tap_en   = 1'b1;
              tap_code = remap_usage(evt_i.button);
            end
          end else if (evt_i.press_kind == KIND_LONG && evt_i.button == BTN_BACK) begin
            exit_d = 1'b0;
            mode_d = MODE_EXIT;
          end
        end
        MODE_APPS: begin
          if (shrt) begin
            if (evt_i.button == BTN_UP) begin
              tap_en   = 1'b1;
              tap_code = USE_RIGHT;
            end else if (evt_i.button == BTN_DOWN) begin
              tap_en   = 1'b1;
              tap_code = USE_LEFT;
            end else if (evt_i.button == BTN_OK) begin
              tap_en   = 1'b1;
              tap_code = USE_RET;
              rel_en   = gui_q;
              mode_d   = MODE_MAIN;
            end else if (evt_i.button == BTN_LEFT) begin
              tap_en   = 1'b1;
              tap_code = USE_UP;
              rel_en   = gui_q;
              mode_d   = MODE_WINS;
            end else if (evt_i.button == BTN_BACK) begin
              rel_en = gui_q;
              mode_d = MODE_MAIN;
            end
          end
        end
        MODE_WINS: begin
          if (shrt) begin
            if (is_dir(evt_i.button)) begin
              tap_en   = 1'b1;
              tap_code = remap_usage(evt_i.button);
            end else if (evt_i.button == BTN_OK) begin
              tap_en   = 1'b1;
              tap_code = USE_RET;
              mode_d   = MODE_MAIN;
            end else if (evt_i.button == BTN_BACK) begin
              press_en = !gui_q;
              tap_en   = 1'b1;
              tap_code = USE_TAB;
              mode_d   = MODE_APPS;
            end
          end
        end
        MODE_EXIT: begin
          if (shrt) begin
            if (evt_i.button == BTN_OK) begin
              exit_d = 1'b1;
              rel_en = gui_q;
            end else if (evt_i.button == BTN_BACK) begin
              exit_d = 1'b0;
              mode_d = MODE_MAIN;
            end
          end
        end
        default: mode_d = mode_q;
      endcase
    end
  end

  assign mod_tap = gui_q || press_en;
  assign gui_d   = press_en ? 1'b1 : (rel_en ? 1'b0 : gui_q);

  always_comb begin
    plan_o.recs = '0;
    n = 2'd0;
    if (press_en) begin
      plan_o.recs[n] = mk_rec(1'b0, USE_GUI, 1'b1);
      n = n + 2'd1;
    end
    if (tap_en) begin
      plan_o.recs[n] = mk_rec(1'b0, tap_code, mod_tap);
      n = n + 2'd1;
      plan_o.recs[n] = mk_rec(1'b1, tap_code, mod_tap);
      n = n + 2'd1;
    end
    if (rel_en) begin
      plan_o.recs[n] = mk_rec(1'b1, USE_GUI, 1'b0);
      n = n + 2'd1;
    end
    if (n == 2'd0) begin
      plan_o.recs[0].mod = gui_q;
      plan_o.cnt = 2'd1;
    end else begin
      plan_o.cnt = n;
    end
    plan_o.mode      = mode_d;
    plan_o.exit_flag = exit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MAIN;
      gui_q  <= 1'b0;
      exit_q <= 1'b0;
    end else if (push_o) begin
      mode_q <= mode_d;
      gui_q  <= gui_d;
      exit_q <= exit_d;
    end
  end

endmodule

// ----- hdl/bhms_queue.sv -----
// Two-entry queue of record plans between the front end and the back end.
// Depends on bhms_pkg.
module bhms_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bhms_pkg::plan_t plan_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bhms_pkg::plan_t plan_o
);
  import bhms_pkg::*;

  plan_t      mem_q [QueueDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(QueueDepth));
  assign valid_o = (count_q != 2'd0);
  assign plan_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- hdl/bhms_back.sv -----
// Back end: steps through the records of the head plan into the output register.
// Depends on bhms_pkg.
module bhms_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              plan_valid_i,
  input  bhms_pkg::plan_t   plan_i,
  output logic              pop_o,
  output bhms_pkg::report_t report_o,
  output logic              report_valid_o,
  input  logic              report_ready_i
);
  import bhms_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  report_t    out_q, out_d;
  logic       take, is_last;
  rec_t       rec;

  assign take    = plan_valid_i && (!out_valid_q || report_ready_i);
  assign rec     = plan_i.recs[idx_q];
  assign is_last = (idx_q == plan_i.cnt - 2'd1);
  assign pop_o   = take && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (take) begin
      idx_d                = is_last ? 2'd0 : idx_q + 2'd1;
      out_valid_d          = 1'b1;
      out_d.report_valid   = rec.act;
      out_d.report_release = rec.rel;
      out_d.usage_code     = rec.code;
      out_d.mode_now       = plan_i.mode;
      out_d.modifier_held  = rec.mod;
      out_d.exit_done      = plan_i.exit_flag;
      out_d.last           = is_last;
    end else if (report_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign report_o       = out_q;
  assign report_valid_o = out_valid_q;

endmodule

// ----- hdl/button_to_hid_mode_sequencer.sv -----
// Button to HID mode sequencer, top level; uses bhms_pkg, bhms_front, bhms_queue, bhms_back.
// Path: an accepted event's plan is written into the plan queue, then its records into the output register.
// Throughput: one record per cycle at the output register while the receiver is ready; an event
// has 1 to 3 records; a two-entry plan queue lets events arrive back to back while it is not full.
// Reset: mode main, GUI modifier not held, exit flag clear, queue and output empty.
module button_to_hid_mode_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bhms_pkg::evt_t    evt_i,
  input  logic              evt_valid_i,
  output logic              evt_ready_o,
  output bhms_pkg::report_t report_o,
  output logic              report_valid_o,
  input  logic              report_ready_i
);
  import bhms_pkg::*;

  logic  push, full, pop, head_valid;
  plan_t plan_in, plan_head;

  bhms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_i),
    .evt_valid_i (evt_valid_i),
    .evt_ready_o (evt_ready_o),
    .queue_full_i(full),
    .push_o      (push),
    .plan_o      (plan_in)
  );

  bhms_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .plan_i (plan_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .plan_o (plan_head)
  );

  bhms_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .plan_valid_i  (head_valid),
    .plan_i        (plan_head),
    .pop_o         (pop),
    .report_o      (report_o),
    .report_valid_o(report_valid_o),
    .report_ready_i(report_ready_i)
  );

  a_noact_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_valid_o && !report_o.report_valid |-> report_o.last)
    else $error("no-action record without last mark");

  a_gui_press_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_valid_o && report_o.report_valid && !report_o.report_release &&
    report_o.usage_code == USE_GUI |-> report_o.modifier_held)
    else $error("GUI press record without modifier held");

  a_gui_rel_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_valid_o && report_o.report_valid && report_o.report_release &&
    report_o.usage_code == USE_GUI |-> !report_o.modifier_held && report_o.last)
    else $error("GUI release record malformed");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("plan queue popped while empty");

endmodule

// ----- tb/sv/button_to_hid_mode_sequencer_tb.sv -----
// Testbench for button_to_hid_mode_sequencer: drives button events, predicts the HID
// report records of each event and checks every record transfer in order.
// Depends on bhms_pkg and the button_to_hid_mode_sequencer RTL.
`timescale 1ns / 100ps

module button_to_hid_mode_sequencer_tb;
  import bhms_pkg::*;

  localparam logic [2:0] BTN_SPARE6 = 3'd6;
  localparam logic [2:0] BTN_SPARE7 = 3'd7;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ItemsPerPhase = 51;

  class hid_report_scoreboard;
    mode_e       mode;
    logic        gui_held;
    logic        exit_flag;
    report_t     event_recs[$];
    report_t     pending[$];
    int unsigned errors;

    function new();
      mode      = MODE_MAIN;
      gui_held  = 1'b0;
      exit_flag = 1'b0;
      errors    = 0;
    endfunction

    function void add_rec(logic rel, logic [7:0] code);
      report_t r;
      r = '0;
      r.report_valid   = 1'b1;
      r.report_release = rel;
      r.usage_code     = code;
      r.modifier_held  = gui_held;
      if (event_recs.size() < MaxRecs) event_recs.push_back(r);
    endfunction

    function void tap(logic [7:0] code);
      add_rec(1'b0, code);
      add_rec(1'b1, code);
    endfunction

    function void release_gui();
      if (gui_held) begin
        gui_held = 1'b0;
        add_rec(1'b1, USE_GUI);
      end
    endfunction

    function void goto_app_switcher();
      if (!gui_held) begin
        gui_held = 1'b1;
        add_rec(1'b0, USE_GUI);
      end
      tap(USE_TAB);
      mode = MODE_APPS;
    endfunction

    function logic remap_tap(logic [2:0] button);
      case (button)
        BTN_LEFT:  tap(USE_UP);
        BTN_UP:    tap(USE_RIGHT);
        BTN_RIGHT: tap(USE_DOWN);
        BTN_DOWN:  tap(USE_LEFT);
        default:   return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void note_event(evt_t e);
      logic    short_press;
      report_t r;
      short_press = (e.press_kind == KIND_SHORT);
      event_recs.delete();
      if (!exit_flag) begin
        case (mode)
          MODE_MAIN: begin
            if (short_press) begin
              if (e.button == BTN_OK) goto_app_switcher();
              else void'(remap_tap(e.button));
            end else if (e.press_kind == KIND_LONG && e.button == BTN_BACK) begin
              exit_flag = 1'b0;
              mode = MODE_EXIT;
            end
          end
          MODE_APPS: begin
            if (short_press) begin
              case (e.button)
                BTN_UP:   tap(USE_RIGHT);
                BTN_DOWN: tap(USE_LEFT);
                BTN_OK: begin
                  tap(USE_RET);
                  release_gui();
                  mode = MODE_MAIN;
                end
                BTN_LEFT: begin
                  tap(USE_UP);
                  release_gui();
                  mode = MODE_WINS;
                end
                BTN_BACK: begin
                  release_gui();
                  mode = MODE_MAIN;
                end
                default: ;
              endcase
            end
          end
          MODE_WINS: begin
            if (short_press && !remap_tap(e.button)) begin
              if (e.button == BTN_OK) begin
                tap(USE_RET);
                mode = MODE_MAIN;
              end else if (e.button == BTN_BACK) begin
                goto_app_switcher();
              end
            end
          end
          default: begin
            if (short_press) begin
              if (e.button == BTN_OK) begin
                exit_flag = 1'b1;
                release_gui();
              end else if (e.button == BTN_BACK) begin
                exit_flag = 1'b0;
                mode = MODE_MAIN;
              end
            end
          end
        endcase
      end
      if (event_recs.size() == 0) begin
        r = '0;
        r.modifier_held = gui_held;
        event_recs.push_back(r);
      end
      foreach (event_recs[k]) begin
        r = event_recs[k];
        r.mode_now  = mode;
        r.exit_done = exit_flag;
        r.last      = (k == event_recs.size() - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_report(report_t r);
      report_t x;
      if (pending.size() == 0) begin
        $error("Report transfer with no record expected: %h", r);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (r.report_valid !== x.report_valid) begin
        $error("report_valid: expected %0d, actual %0d", x.report_valid, r.report_valid);
        errors++;
      end
      if (r.report_release !== x.report_release) begin
        $error("report_release: expected %0d, actual %0d", x.report_release,
               r.report_release);
        errors++;
      end
      if (r.usage_code !== x.usage_code) begin
        $error("usage_code: expected %0h, actual %0h", x.usage_code, r.usage_code);
        errors++;
      end
      if (r.mode_now !== x.mode_now) begin
        $error("mode_now: expected %0d, actual %0d", x.mode_now, r.mode_now);
        errors++;
      end
      if (r.modifier_held !== x.modifier_held) begin
        $error("modifier_held: expected %0d, actual %0d", x.modifier_held,
               r.modifier_held);
        errors++;
      end
      if (r.exit_done !== x.exit_done) begin
        $error("exit_done: expected %0d, actual %0d", x.exit_done, r.exit_done);
        errors++;
      end
      if (r.last !== x.last) begin
        $error("last: expected %0d, actual %0d", x.last, r.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  evt_t        evt_i = '0;
  logic        evt_valid_i = 1'b0;
  logic        evt_ready_o;
  report_t     report_o;
  logic        report_valid_o;
  logic        report_ready_i = 1'b0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;
  hid_report_scoreboard sb = new();

  button_to_hid_mode_sequencer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_i          (evt_i),
    .evt_valid_i    (evt_valid_i),
    .evt_ready_o    (evt_ready_o),
    .report_o       (report_o),
    .report_valid_o (report_valid_o),
    .report_ready_i (report_ready_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && report_valid_o && report_ready_i) sb.check_report(report_o);
    report_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_event(input logic [2:0] button, input logic [1:0] kind);
    evt_t e;
    e.button     = button;
    e.press_kind = kind;
    while ($urandom_range(99) < idle_pct) begin
      evt_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    evt_i       <= e;
    evt_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!evt_ready_o) @(posedge clk_i);
    sb.note_event(e);
  endtask

  // Mostly short presses on real keys so the mode machine is walked deeply.
  // Confirming exit is held back for the end, since it silences the block.
  function automatic evt_t random_event();
    evt_t        e;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      e.button     = 3'($urandom_range(BTN_BACK));
      e.press_kind = KIND_SHORT;
    end else if (pick < 85) begin
      e.button     = 3'($urandom_range(BTN_BACK));
      e.press_kind = KIND_LONG;
    end else begin
      e.button     = 3'($urandom_range(BTN_SPARE7));
      e.press_kind = 2'($urandom_range(KIND_SPARE));
    end
    if (sb.mode == MODE_EXIT && e.button == BTN_OK && e.press_kind == KIND_SHORT) begin
      e.button = BTN_BACK;
    end
    return e;
  endfunction

  task automatic run_random(input int unsigned sender_idle, input int unsigned receiver_stall);
    evt_t e;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (ItemsPerPhase) begin
      e = random_event();
      send_event(e.button, e.press_kind);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(BTN_UP, KIND_SHORT);
    send_event(BTN_DOWN, KIND_SHORT);
    send_event(BTN_LEFT, KIND_SHORT);
    send_event(BTN_RIGHT, KIND_SHORT);
    send_event(BTN_BACK, KIND_SHORT);
    send_event(BTN_UP, KIND_LONG);
    send_event(BTN_SPARE7, KIND_SHORT);
    send_event(BTN_SPARE6, KIND_SPARE);
    send_event(BTN_OK, KIND_OTHER);
    send_event(BTN_OK, KIND_SHORT);
    send_event(BTN_UP, KIND_SHORT);
    send_event(BTN_DOWN, KIND_SHORT);
    send_event(BTN_RIGHT, KIND_SHORT);
    send_event(BTN_OK, KIND_LONG);
    send_event(BTN_LEFT, KIND_SHORT);
    send_event(BTN_UP, KIND_SHORT);
    send_event(BTN_BACK, KIND_LONG);
    send_event(BTN_BACK, KIND_SHORT);
    send_event(BTN_BACK, KIND_SHORT);
    send_event(BTN_OK, KIND_SHORT);
    send_event(BTN_OK, KIND_SHORT);
    send_event(BTN_OK, KIND_SHORT);
    send_event(BTN_LEFT, KIND_SHORT);
    send_event(BTN_OK, KIND_SHORT);
    send_event(BTN_BACK, KIND_LONG);
    send_event(BTN_UP, KIND_SHORT);
    send_event(BTN_BACK, KIND_SHORT);

    run_random(0, 0);
    run_random(83, 0);
    run_random(0, 83);
    run_random(13, 13);

    // Leave the app switcher before confirming exit, then check that events are ignored.
    idle_pct  = 0;
    stall_pct = 0;
    if (sb.mode == MODE_APPS || sb.mode == MODE_WINS) send_event(BTN_OK, KIND_SHORT);
    if (sb.mode == MODE_MAIN) send_event(BTN_BACK, KIND_LONG);
    send_event(BTN_OK, KIND_SHORT);
    send_event(BTN_UP, KIND_SHORT);
    send_event(BTN_BACK, KIND_SHORT);
    send_event(BTN_BACK, KIND_LONG);
    evt_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
